// File: rtl/swg_pkg.sv
// Package for the stepped waveform generator: widths, register codes, wave modes
// and the structs passed into the front stage and from it to the code stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swg_pkg;

    // Phase counter width and DAC code width.
    localparam int STEP_BITS = 8;
    localparam int DAC_BITS  = 12;
    localparam int WORD_BITS = 16;

    // Step counts run up to 2**STEP_BITS, so they need one extra bit.
    localparam int STEPS_W   = STEP_BITS + 1;
    localparam int CFG_W     = STEPS_W;
    localparam int PROD_W    = DAC_BITS + STEP_BITS;

    localparam logic [STEPS_W-1:0]   MAX_STEPS  = STEPS_W'(1 << STEP_BITS);
    localparam logic [DAC_BITS-1:0]  FULL_SCALE = DAC_BITS'(4095);
    localparam logic [WORD_BITS-1:0] CTRL_WORD  = WORD_BITS'(16'h3000);

    // Step counts after reset and the increments that belong to them.
    localparam logic [STEPS_W-1:0]  SAW_STEPS_RESET = STEPS_W'(16);
    localparam logic [STEPS_W-1:0]  TRI_STEPS_RESET = STEPS_W'(8);
    localparam logic [DAC_BITS-1:0] SAW_INC_RESET   = DAC_BITS'(4095 / 16);
    localparam logic [DAC_BITS-1:0] TRI_INC_RESET   = DAC_BITS'(4095 / 4);

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_DC     = 3'd1,
        MODE_SQUARE = 3'd2,
        MODE_SAW    = 3'd3,
        MODE_TRI    = 3'd4
    } wave_mode_t;

    typedef enum logic [1:0] {
        REG_WAVE_MODE = 2'd0,
        REG_SAW_STEPS = 2'd1,
        REG_TRI_STEPS = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ACT_TICK    = 1'b0,
        ACT_RESTART = 1'b1
    } action_t;

    // Current configuration as seen by the front stage.
    typedef struct packed {
        logic [2:0]          mode;
        logic [STEPS_W-1:0]  saw_steps;
        logic [STEPS_W-1:0]  tri_steps;
        logic [DAC_BITS-1:0] saw_inc;
        logic [DAC_BITS-1:0] tri_inc;
        logic                busy;
    } swg_cfg_t;

    // One operation handed from the front stage to the code stage.
    typedef struct packed {
        logic                 restart;
        logic [2:0]           mode;
        logic [DAC_BITS-1:0]  level;
        logic                 parity;
        logic [DAC_BITS-1:0]  inc;
        logic [STEP_BITS-1:0] factor;
    } swg_op_t;

endpackage

`default_nettype wire

// File: rtl/swg_in_if.sv
// Input channel of the stepped waveform generator: action and level with valid/ready.
// Depends on swg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface swg_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [swg_pkg::DAC_BITS-1:0] level;

    modport source (output valid, output action, output level, input ready);
    modport sink   (input valid, input action, input level, output ready);
endinterface

`default_nettype wire

// File: rtl/swg_out_if.sv
// Output channel of the stepped waveform generator: DAC code and serial word.
// Depends on swg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface swg_out_if;
    logic                          valid;
    logic                          ready;
    logic [swg_pkg::DAC_BITS-1:0]  dac_value;
    logic [swg_pkg::WORD_BITS-1:0] dac_word;

    modport source (output valid, output dac_value, output dac_word, input ready);
    modport sink   (input valid, input dac_value, input dac_word, output ready);
endinterface

`default_nettype wire

// File: rtl/swg_div.sv
// Bit-serial restoring divider that forms the full-scale code divided by a step count.
// Depends on swg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swg_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [swg_pkg::STEPS_W-1:0]     divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic [swg_pkg::DAC_BITS-1:0]         quotient
);

    localparam int CNT_W = $clog2(swg_pkg::DAC_BITS + 1);

    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic [swg_pkg::STEPS_W-1:0]     rem_reg, rem_next;
    logic [swg_pkg::STEPS_W-1:0]     div_reg, div_next;
    logic [swg_pkg::DAC_BITS-1:0]    q_reg, q_next;
    logic [swg_pkg::STEPS_W:0]       rem_sh;
    logic [swg_pkg::STEPS_W:0]       diff;
    logic                            fits;

    // The dividend is shifted out of the top of q_reg while quotient bits enter below.
    assign rem_sh = {rem_reg, q_reg[swg_pkg::DAC_BITS-1]};
    assign diff   = rem_sh - {1'b0, div_reg};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        if (start)
        begin
            cnt_next = CNT_W'(swg_pkg::DAC_BITS);
            rem_next = '0;
            div_next = divisor;
            q_next   = swg_pkg::FULL_SCALE;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = fits ? diff[swg_pkg::STEPS_W-1:0] : rem_sh[swg_pkg::STEPS_W-1:0];
            q_next    = {q_reg[swg_pkg::DAC_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign busy     = (cnt_reg != '0) || done_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: rtl/swg_phase.sv
// Front stage: tick parity and phase counters, operand selection for the code stage.
// Depends on swg_pkg and swg_in_if.
`timescale 1ns / 1ps
`default_nettype none

module swg_phase (
    input  wire logic                clk,
    input  wire logic                rst_n,
    swg_in_if.sink                   wave_in,
    input  wire swg_pkg::swg_cfg_t   cfg,
    input  wire logic                op_take,
    output logic                     op_valid,
    output swg_pkg::swg_op_t         op
);

    logic                            parity_reg, parity_next;
    logic [swg_pkg::STEP_BITS-1:0]   saw_phase_reg, saw_phase_next;
    logic [swg_pkg::STEP_BITS-1:0]   tri_phase_reg, tri_phase_next;
    logic                            op_valid_reg, op_valid_next;
    swg_pkg::swg_op_t                op_reg, op_next;

    logic                            accept;
    logic [swg_pkg::STEP_BITS-1:0]   sp, tp, half, tri_fac;
    logic [swg_pkg::STEPS_W-1:0]     sp_inc, tp_inc;

    assign wave_in.ready = !cfg.busy && (!op_valid_reg || op_take);
    assign accept        = wave_in.valid && wave_in.ready;

    // A phase left at or above a shrunken step count counts as zero.
    assign sp     = ({1'b0, saw_phase_reg} < cfg.saw_steps) ? saw_phase_reg : '0;
    assign tp     = ({1'b0, tri_phase_reg} < cfg.tri_steps) ? tri_phase_reg : '0;
    assign half   = cfg.tri_steps[swg_pkg::STEPS_W-1:1];
    assign sp_inc = {1'b0, sp} + swg_pkg::STEPS_W'(1);
    assign tp_inc = {1'b0, tp} + swg_pkg::STEPS_W'(1);

    // On the falling half the factor is half - (tp - half), which is tri_steps - tp.
    assign tri_fac = (tp < half) ? tp
                                 : swg_pkg::STEP_BITS'(cfg.tri_steps - {1'b0, tp});

    always_comb
    begin
        parity_next    = parity_reg;
        saw_phase_next = saw_phase_reg;
        tri_phase_next = tri_phase_reg;
        op_next        = op_reg;
        op_valid_next  = op_valid_reg;

        if (op_take)
        begin
            op_valid_next = 1'b0;
        end

        if (accept)
        begin
            op_valid_next  = 1'b1;
            op_next.restart = (wave_in.action == swg_pkg::ACT_RESTART);
            op_next.mode    = cfg.mode;
            op_next.level   = wave_in.level;
            op_next.parity  = parity_reg;
            if (cfg.mode == swg_pkg::MODE_SAW)
            begin
                op_next.inc    = cfg.saw_inc;
                op_next.factor = sp;
            end
            else
            begin
                op_next.inc    = cfg.tri_inc;
                op_next.factor = tri_fac;
            end

            if (wave_in.action == swg_pkg::ACT_RESTART)
            begin
                parity_next    = 1'b0;
                saw_phase_next = '0;
                tri_phase_next = '0;
            end
            else
            begin
                parity_next    = !parity_reg;
                saw_phase_next = (sp_inc >= cfg.saw_steps) ? '0
                                 : sp_inc[swg_pkg::STEP_BITS-1:0];
                tri_phase_next = (tp_inc >= cfg.tri_steps) ? '0
                                 : tp_inc[swg_pkg::STEP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            saw_phase_reg <= '0;
            tri_phase_reg <= '0;
            op_valid_reg  <= 1'b0;
        end
        else
        begin
            parity_reg    <= parity_next;
            saw_phase_reg <= saw_phase_next;
            tri_phase_reg <= tri_phase_next;
            op_valid_reg  <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    // A restart leaves every counter at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (wave_in.action == swg_pkg::ACT_RESTART)
        |=> (saw_phase_reg == '0) && (tri_phase_reg == '0) && !parity_reg)
        else $error("counters not cleared by restart");

    // Every tick flips the parity that square mode uses.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (wave_in.action == swg_pkg::ACT_TICK)
        |=> parity_reg != $past(parity_reg))
        else $error("tick parity did not toggle");

endmodule

`default_nettype wire

// File: rtl/swg_code.sv
// Code stage: multiplies increment by phase factor, picks the mode result and
// holds it in the output register. Depends on swg_pkg and swg_out_if.
`timescale 1ns / 1ps
`default_nettype none

module swg_code (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    input  wire swg_pkg::swg_op_t    op,
    output logic                     op_take,
    swg_out_if.source                wave_out
);

    logic                            valid_reg, valid_next;
    logic [swg_pkg::DAC_BITS-1:0]    value_reg, value_next;
    logic [swg_pkg::DAC_BITS-1:0]    code;
    logic [swg_pkg::PROD_W-1:0]      prod;

    assign op_take = op_valid && (!valid_reg || wave_out.ready);
    assign prod    = op.inc * op.factor;

    always_comb
    begin
        code = '0;
        if (!op.restart)
        begin
            case (op.mode)
                swg_pkg::MODE_DC:     code = op.level;
                swg_pkg::MODE_SQUARE: code = op.parity ? op.level : '0;
                swg_pkg::MODE_SAW:    code = prod[swg_pkg::DAC_BITS-1:0];
                swg_pkg::MODE_TRI:    code = prod[swg_pkg::DAC_BITS-1:0];
                default:              code = '0;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (wave_out.ready)
        begin
            valid_next = 1'b0;
        end
        if (op_take)
        begin
            valid_next = 1'b1;
            value_next = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign wave_out.valid     = valid_reg;
    assign wave_out.dac_value = value_reg;
    assign wave_out.dac_word  = swg_pkg::WORD_BITS'(value_reg) | swg_pkg::CTRL_WORD;

    // A restart always comes out as the zero code with the control bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_take && op.restart
        |=> (wave_out.dac_value == '0) && (wave_out.dac_word == swg_pkg::CTRL_WORD))
        else $error("restart did not produce the zero code");

endmodule

`default_nettype wire

// File: rtl/stepped_waveform_generator_top.sv
// Top level of the stepped waveform generator: configuration registers, the two
// increment dividers, the front stage and the code stage.
// Depends on swg_pkg, swg_in_if, swg_out_if, swg_div, swg_phase and swg_code.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Payload                         | Handshake
// ----------+-----------+---------------------------------+------------------------
// wave_in   | sink      | action (1), level (12)          | valid/ready
// wave_out  | source    | dac_value (12), dac_word (16)   | valid/ready
// config    | write     | cfg_index (2), cfg_data (9)     | cfg_we, no back-pressure
//
// Each transaction on wave_in yields exactly one transaction on wave_out, and a
// new transaction is taken in every cycle while the output side is not stalled
// and no division is running; the path is one register for phase and operand
// selection, then one 12 x 8 multiply feeding the output register.
// Writing a step count starts a bit-serial division of the full-scale code by the
// step count (or half of it for the triangle); wave_in is held off until it finishes.
// Reset is asynchronous and active low; it restores wave_mode 4, saw_steps 16,
// tri_steps 8 and clears all counters. A stalled wave_out keeps its result while
// the front stage still takes one more transaction.

module stepped_waveform_generator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swg_in_if.sink                               wave_in,
    swg_out_if.source                            wave_out,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [swg_pkg::CFG_W-1:0]       cfg_data
);

    logic [2:0]                      mode_reg, mode_next;
    logic [swg_pkg::STEPS_W-1:0]     saw_steps_reg, saw_steps_next;
    logic [swg_pkg::STEPS_W-1:0]     tri_steps_reg, tri_steps_next;
    logic [swg_pkg::DAC_BITS-1:0]    saw_inc_reg, saw_inc_next;
    logic [swg_pkg::DAC_BITS-1:0]    tri_inc_reg, tri_inc_next;

    logic [swg_pkg::STEPS_W-1:0]     saw_clamped;
    logic [swg_pkg::STEPS_W-1:0]     tri_even;
    logic [swg_pkg::STEPS_W-1:0]     tri_clamped;
    logic [swg_pkg::STEPS_W-1:0]     tri_half;

    logic                            saw_start, tri_start;
    logic                            saw_busy, tri_busy;
    logic                            saw_done, tri_done;
    logic [swg_pkg::DAC_BITS-1:0]    saw_quot, tri_quot;

    swg_pkg::swg_cfg_t               cfg;
    swg_pkg::swg_op_t                op;
    logic                            op_valid;
    logic                            op_take;

    // Out-of-range step counts are pulled into range; the triangle count is
    // rounded down to an even number first.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            saw_clamped = swg_pkg::STEPS_W'(1);
        end
        else if (cfg_data > swg_pkg::MAX_STEPS)
        begin
            saw_clamped = swg_pkg::MAX_STEPS;
        end
        else
        begin
            saw_clamped = cfg_data;
        end

        tri_even = {cfg_data[swg_pkg::CFG_W-1:1], 1'b0};
        if (tri_even < swg_pkg::STEPS_W'(2))
        begin
            tri_clamped = swg_pkg::STEPS_W'(2);
        end
        else if (tri_even > swg_pkg::MAX_STEPS)
        begin
            tri_clamped = swg_pkg::MAX_STEPS;
        end
        else
        begin
            tri_clamped = tri_even;
        end
        tri_half = {1'b0, tri_clamped[swg_pkg::STEPS_W-1:1]};
    end

    always_comb
    begin
        mode_next      = mode_reg;
        saw_steps_next = saw_steps_reg;
        tri_steps_next = tri_steps_reg;
        saw_start      = 1'b0;
        tri_start      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                swg_pkg::REG_WAVE_MODE:
                begin
                    mode_next = cfg_data[2:0];
                end
                swg_pkg::REG_SAW_STEPS:
                begin
                    saw_steps_next = saw_clamped;
                    saw_start      = 1'b1;
                end
                swg_pkg::REG_TRI_STEPS:
                begin
                    tri_steps_next = tri_clamped;
                    tri_start      = 1'b1;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        saw_inc_next = saw_done ? saw_quot : saw_inc_reg;
        tri_inc_next = tri_done ? tri_quot : tri_inc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= swg_pkg::MODE_TRI;
            saw_steps_reg <= swg_pkg::SAW_STEPS_RESET;
            tri_steps_reg <= swg_pkg::TRI_STEPS_RESET;
            saw_inc_reg   <= swg_pkg::SAW_INC_RESET;
            tri_inc_reg   <= swg_pkg::TRI_INC_RESET;
        end
        else
        begin
            mode_reg      <= mode_next;
            saw_steps_reg <= saw_steps_next;
            tri_steps_reg <= tri_steps_next;
            saw_inc_reg   <= saw_inc_next;
            tri_inc_reg   <= tri_inc_next;
        end
    end

    // Sawtooth increment: full scale over the step count.
    swg_div u_saw_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (saw_start),
        .divisor  (saw_clamped),
        .busy     (saw_busy),
        .done     (saw_done),
        .quotient (saw_quot)
    );

    // Triangle increment: full scale over half the period.
    swg_div u_tri_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tri_start),
        .divisor  (tri_half),
        .busy     (tri_busy),
        .done     (tri_done),
        .quotient (tri_quot)
    );

    assign cfg.mode      = mode_reg;
    assign cfg.saw_steps = saw_steps_reg;
    assign cfg.tri_steps = tri_steps_reg;
    assign cfg.saw_inc   = saw_inc_reg;
    assign cfg.tri_inc   = tri_inc_reg;
    assign cfg.busy      = saw_busy || tri_busy;

    swg_phase u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .wave_in  (wave_in),
        .cfg      (cfg),
        .op_take  (op_take),
        .op_valid (op_valid),
        .op       (op)
    );

    swg_code u_code (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .wave_out (wave_out)
    );

    // No transaction may enter while an increment is still being computed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (saw_busy || tri_busy) |-> !(wave_in.valid && wave_in.ready))
        else $error("input taken while an increment was being divided");

    // A step count write always launches its divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && ((cfg_index == swg_pkg::REG_SAW_STEPS) || (cfg_index == swg_pkg::REG_TRI_STEPS))
        |=> (saw_busy || tri_busy))
        else $error("step count write did not start a division");

endmodule

`default_nettype wire

// File: dv/tb_stepped_waveform_generator_top.sv
// Self-checking testbench for the stepped waveform generator: drives tick and restart
// transactions, tracks the expected DAC codes with its own phase-counter model.
// Depends on swg_pkg, swg_in_if, swg_out_if and stepped_waveform_generator_top.
`timescale 1ns / 1ps

module tb_stepped_waveform_generator_top;

    import swg_pkg::*;

    // Stimulus size and run limits.
    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LONG_HOLD      = 80;

    // Register index that the block does not decode, and a mode code past the last one.
    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // Level codes at the ends of the range and in the middle.
    localparam logic [DAC_BITS-1:0] LEVEL_MIN = '0;
    localparam logic [DAC_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [DAC_BITS-1:0] LEVEL_MID = DAC_BITS'(2048);

    typedef struct {
        action_t             action;
        logic [DAC_BITS-1:0] level;
    } wave_item_t;

    typedef struct {
        logic [DAC_BITS-1:0]  value;
        logic [WORD_BITS-1:0] word;
    } dac_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    swg_in_if  wave_in_ch ();
    swg_out_if wave_out_ch ();

    stepped_waveform_generator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .wave_in   (wave_in_ch),
        .wave_out  (wave_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Transactions waiting to be offered, and DAC results waiting to come out.
    wave_item_t  stim_queue[$];
    dac_result_t dac_expected[$];

    // Shadow of the configuration and of the phase counters.
    logic [2:0] cur_mode;
    int         saw_period;
    int         tri_period;
    int         saw_step_size;
    int         tri_step_size;
    logic       odd_tick;
    logic [STEP_BITS-1:0] saw_pos;
    logic [STEP_BITS-1:0] tri_pos;

    // Bookkeeping for the summary.
    int error_count    = 0;
    int queued_total   = 0;
    int accepted_in    = 0;
    int accepted_out   = 0;
    int restart_count  = 0;
    int reg_writes     = 0;
    int mode_ticks[8]  = '{default: 0};
    int idle_cycles    = 0;

    // Idle control for both sides of the block.
    int send_gap       = 0;
    bit send_calm      = 1'b0;
    int recv_stall     = 0;
    bit recv_calm      = 1'b0;
    bit long_hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Waveform predictor
    // ------------------------------------------------------------------

    // A sawtooth step count is clamped to 1..256; its increment follows from it.
    function automatic void load_saw_period(logic [CFG_W-1:0] raw);
        int n;
        n = raw;
        if (n < 1)
            n = 1;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        saw_period    = n;
        saw_step_size = FULL_SCALE / n;
    endfunction

    // The triangle count is rounded down to even, clamped to 2..256, and the
    // increment is taken over half a period.
    function automatic void load_tri_period(logic [CFG_W-1:0] raw);
        int n;
        n = raw & ~1;
        if (n < 2)
            n = 2;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        tri_period    = n;
        tri_step_size = FULL_SCALE / (n / 2);
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_WAVE_MODE: cur_mode = data[2:0];
            REG_SAW_STEPS: load_saw_period(data);
            REG_TRI_STEPS: load_tri_period(data);
            default: ;
        endcase
    endfunction

    function automatic void reset_waveform_state();
        cur_mode = MODE_TRI;
        load_saw_period(SAW_STEPS_RESET);
        load_tri_period(TRI_STEPS_RESET);
        odd_tick = 1'b0;
        saw_pos  = '0;
        tri_pos  = '0;
    endfunction

    // Works out the DAC code for one transaction and advances the counters.
    function automatic dac_result_t next_dac_code(action_t act, logic [DAC_BITS-1:0] lvl);
        dac_result_t res;
        int sp;
        int tp;
        int half;
        int code;
        code = 0;
        if (act == ACT_RESTART)
        begin
            odd_tick = 1'b0;
            saw_pos  = '0;
            tri_pos  = '0;
        end
        else
        begin
            // A phase left beyond a period that has since shrunk counts as zero.
            sp   = (saw_pos < saw_period) ? saw_pos : 0;
            tp   = (tri_pos < tri_period) ? tri_pos : 0;
            half = tri_period / 2;
            case (cur_mode)
                MODE_DC:     code = lvl;
                MODE_SQUARE: code = odd_tick ? lvl : 0;
                MODE_SAW:    code = saw_step_size * sp;
                MODE_TRI:    code = (tp < half) ? tri_step_size * tp
                                                : tri_step_size * (half - (tp - half));
                default:     code = 0;
            endcase
            odd_tick = ~odd_tick;
            saw_pos  = STEP_BITS'((sp + 1 >= saw_period) ? 0 : sp + 1);
            tri_pos  = STEP_BITS'((tp + 1 >= tri_period) ? 0 : tp + 1);
        end
        res.value = code[DAC_BITS-1:0];
        res.word  = WORD_BITS'(code[DAC_BITS-1:0]) | CTRL_WORD;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one, none at all in a calm stretch.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Step counts lean on the clamps and the extremes, with short periods
    // frequent so that wraps happen often within one batch.
    function automatic int pick_steps();
        case ($urandom_range(5))
            0:       return $urandom_range(0, 2);
            1:       return MAX_STEPS;
            2:       return $urandom_range(257, 511);
            3, 4:    return $urandom_range(1, 24);
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    function automatic logic [DAC_BITS-1:0] pick_level();
        case ($urandom_range(7))
            0:       return LEVEL_MIN;
            1:       return LEVEL_MAX;
            default: return DAC_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_item(action_t act, logic [DAC_BITS-1:0] lvl);
        wave_item_t item;
        item.action = act;
        item.level  = lvl;
        stim_queue.push_back(item);
        queued_total++;
    endtask

    // Returns on a falling edge once every transaction has gone in and every
    // result has come out, so the block is idle for a register write.
    task automatic settle();
        @(negedge clk);
        while (stim_queue.size() != 0 || dac_expected.size() != 0)
            @(negedge clk);
    endtask

    // One write cycle on the configuration port, mirrored into the shadow copy.
    task automatic write_reg(logic [1:0] idx, int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(value);
        apply_reg(idx, CFG_W'(value));
        reg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input side: driver on the falling edge, acceptance on the rising edge
    // ------------------------------------------------------------------

    // A transaction stays on the bus until it is taken; a gap is only started
    // right after an acceptance, so valid never drops under a pending offer.
    always @(negedge clk)
    begin
        if (!rst_n)
            wave_in_ch.valid <= 1'b0;
        else if (send_gap > 0)
        begin
            wave_in_ch.valid <= 1'b0;
            send_gap = send_gap - 1;
        end
        else if (stim_queue.size() > 0)
        begin
            wave_in_ch.valid  <= 1'b1;
            wave_in_ch.action <= stim_queue[0].action;
            wave_in_ch.level  <= stim_queue[0].level;
        end
        else
            wave_in_ch.valid <= 1'b0;
    end

    // Each accepted transaction is run through the predictor right away. The
    // expectation is pushed before the item leaves the queue so the idle test
    // in settle never sees both queues empty in between.
    always @(posedge clk)
    begin
        if (rst_n && wave_in_ch.valid && wave_in_ch.ready)
        begin
            dac_expected.push_back(next_dac_code(action_t'(wave_in_ch.action),
                                                 wave_in_ch.level));
            if (wave_in_ch.action == ACT_RESTART)
                restart_count++;
            else
                mode_ticks[cur_mode]++;
            accepted_in++;
            stim_queue.pop_front();
            send_gap = pick_gap(send_calm);
            if ($urandom_range(63) == 0)
                send_calm = !send_calm;
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready on the falling edge, checking on the rising edge
    // ------------------------------------------------------------------

    // Random stalls, calm stretches, and one long hold-off while the sender
    // still has plenty queued, so the pipeline fills and stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
            wave_out_ch.ready <= 1'b0;
        else
        begin
            if (recv_stall == 0 && !long_hold_done && stim_queue.size() > 40)
            begin
                recv_stall     = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (recv_stall == 0 && !recv_calm && $urandom_range(3) == 0)
                recv_stall = pick_gap(1'b0);

            if (recv_stall > 0)
            begin
                wave_out_ch.ready <= 1'b0;
                recv_stall = recv_stall - 1;
            end
            else
                wave_out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        dac_result_t want;
        if (rst_n && wave_out_ch.valid && wave_out_ch.ready)
        begin
            accepted_out++;
            if ($urandom_range(63) == 0)
                recv_calm = !recv_calm;
            if (dac_expected.size() == 0)
            begin
                $error("unexpected result transaction: dac_value %0h, dac_word %0h",
                       wave_out_ch.dac_value, wave_out_ch.dac_word);
                error_count++;
            end
            else
            begin
                want = dac_expected.pop_front();
                if (wave_out_ch.dac_value !== want.value)
                begin
                    $error("dac_value: expected %0h, got %0h",
                           want.value, wave_out_ch.dac_value);
                    error_count++;
                end
                if (wave_out_ch.dac_word !== want.word)
                begin
                    $error("dac_word: expected %0h, got %0h",
                           want.word, wave_out_ch.dac_word);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any stretch with no transaction and no register write that
    // runs far past the longest legal stall ends the run.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((wave_in_ch.valid && wave_in_ch.ready) ||
            (wave_out_ch.valid && wave_out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d results still due",
                     idle_cycles, dac_expected.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  batch;
        bit  first_batch;
        int  pick;
        int  mode_code;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        wave_in_ch.valid   = 1'b0;
        wave_in_ch.action  = ACT_TICK;
        wave_in_ch.level   = '0;
        wave_out_ch.ready  = 1'b0;
        reset_waveform_state();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Triangle with the reset step count, across a restart in mid-ramp.
        queue_item(ACT_TICK, LEVEL_MIN);
        queue_item(ACT_TICK, LEVEL_MAX);
        queue_item(ACT_TICK, LEVEL_MID);
        queue_item(ACT_RESTART, LEVEL_MAX);
        queue_item(ACT_TICK, LEVEL_MIN);
        settle();

        // DC follows the level at both ends of its range.
        write_reg(REG_WAVE_MODE, MODE_DC);
        queue_item(ACT_TICK, LEVEL_MIN);
        queue_item(ACT_TICK, LEVEL_MAX);
        settle();

        // Square alternates between zero and the level.
        write_reg(REG_WAVE_MODE, MODE_SQUARE);
        repeat (3) queue_item(ACT_TICK, LEVEL_MAX);
        settle();

        // Sawtooth with a zero step count, which behaves as one step.
        write_reg(REG_WAVE_MODE, MODE_SAW);
        write_reg(REG_SAW_STEPS, 0);
        repeat (2) queue_item(ACT_TICK, LEVEL_MAX);
        settle();

        // An oversized count clamps to the maximum; shrinking it afterwards
        // leaves the phase beyond the new period, which must read as zero.
        write_reg(REG_SAW_STEPS, 300);
        repeat (3) queue_item(ACT_TICK, LEVEL_MID);
        settle();
        write_reg(REG_SAW_STEPS, 2);
        repeat (2) queue_item(ACT_TICK, LEVEL_MID);
        settle();

        // Triangle: oversized count, a count below the minimum that also
        // strands the phase, then an odd count that rounds down.
        write_reg(REG_WAVE_MODE, MODE_TRI);
        write_reg(REG_TRI_STEPS, 511);
        repeat (3) queue_item(ACT_TICK, LEVEL_MIN);
        settle();
        write_reg(REG_TRI_STEPS, 1);
        repeat (2) queue_item(ACT_TICK, LEVEL_MIN);
        settle();
        write_reg(REG_TRI_STEPS, 7);
        queue_item(ACT_TICK, LEVEL_MAX);
        settle();

        // An unused mode code gives zero; a write to an undecoded index is dropped.
        write_reg(REG_WAVE_MODE, MODE_UNUSED_HI);
        write_reg(REG_UNUSED, 511);
        queue_item(ACT_TICK, LEVEL_MAX);
        settle();

        // Random phases: a fresh mix of registers, then a batch of ticks with
        // occasional restarts. The first batch is large enough to be caught by
        // the long output hold-off.
        first_batch = 1'b1;
        while (queued_total < ITEM_TARGET)
        begin
            pick = $urandom_range(1, 7);
            if (pick[0])
            begin
                mode_code = ($urandom_range(7) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(0, 4);
                write_reg(REG_WAVE_MODE, mode_code);
            end
            if (pick[1])
                write_reg(REG_SAW_STEPS, pick_steps());
            if (pick[2])
                write_reg(REG_TRI_STEPS, pick_steps());

            batch = first_batch ? 100 : $urandom_range(20, 100);
            first_batch = 1'b0;
            repeat (batch)
                queue_item(($urandom_range(15) == 0) ? ACT_RESTART : ACT_TICK,
                           pick_level());
            settle();
        end

        // Everything is in and out; let the clock run on so the pipeline can
        // show any stray result.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input and %0d result transactions, %0d restarts, %0d register writes.",
                 accepted_in, accepted_out, restart_count, reg_writes);
        $display("Ticks per mode: off %0d, dc %0d, square %0d, saw %0d, tri %0d, unused %0d.",
                 mode_ticks[MODE_OFF], mode_ticks[MODE_DC], mode_ticks[MODE_SQUARE],
                 mode_ticks[MODE_SAW], mode_ticks[MODE_TRI],
                 mode_ticks[5] + mode_ticks[6] + mode_ticks[7]);
        if (error_count == 0 && dac_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
